[hdl/cesd_pkg.sv]
`default_nettype none

package cesd_pkg;

  // character codes
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_7    = 8'h37;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_F_UP = 8'h46;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_F_LO = 8'h66;
  localparam logic [7:0] CH_QM   = 8'h3F;

  // named escape letters and their control codes
  localparam logic [7:0] CH_LET_A = 8'h61;
  localparam logic [7:0] CH_LET_B = 8'h62;
  localparam logic [7:0] CH_LET_F = 8'h66;
  localparam logic [7:0] CH_LET_N = 8'h6E;
  localparam logic [7:0] CH_LET_R = 8'h72;
  localparam logic [7:0] CH_LET_T = 8'h74;
  localparam logic [7:0] CH_LET_V = 8'h76;
  localparam logic [7:0] CTL_BEL  = 8'h07;
  localparam logic [7:0] CTL_BS   = 8'h08;
  localparam logic [7:0] CTL_FF   = 8'h0C;
  localparam logic [7:0] CTL_LF   = 8'h0A;
  localparam logic [7:0] CTL_CR   = 8'h0D;
  localparam logic [7:0] CTL_HT   = 8'h09;
  localparam logic [7:0] CTL_VT   = 8'h0B;

  // front queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one character with its classification
  typedef struct packed {
    logic [7:0] ch;
    logic       is_bsl;
    logic       is_nul;
    logic       is_hex;
    logic       is_oct;
    logic [3:0] hex_val;
    logic [7:0] named_val;
  } cesd_char_t;

  // queued input transaction
  typedef struct packed {
    cesd_char_t info;
    logic       last;
  } cesd_item_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] byte_val;
    logic       run_last;
    logic       stream_end;
    logic       error;
  } cesd_res_t;

endpackage

`default_nettype wire

[hdl/cesd_front.sv]
`default_nettype none

module cesd_front import cesd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] char_in_i,
  input  wire logic       last_in_i,
  output logic            in_ready_o,
  output logic            q_valid_o,
  output cesd_item_t      q_item_o,
  input  wire logic       q_ready_i
);

  // character classification done once, at accept time
  function automatic cesd_char_t classify(logic [7:0] ch);
    cesd_char_t c;
    c.ch     = ch;
    c.is_bsl = (ch == CH_BSL);
    c.is_nul = (ch == CH_NUL);
    c.is_hex = ch inside {[CH_0:CH_9], [CH_A_UP:CH_F_UP], [CH_A_LO:CH_F_LO]};
    c.is_oct = ch inside {[CH_0:CH_7]};
    c.hex_val = (ch inside {[CH_0:CH_9]}) ? ch[3:0] : ch[3:0] + 4'd9;
    case (ch)
      CH_LET_A: c.named_val = CTL_BEL;
      CH_LET_B: c.named_val = CTL_BS;
      CH_LET_F: c.named_val = CTL_FF;
      CH_LET_N: c.named_val = CTL_LF;
      CH_LET_R: c.named_val = CTL_CR;
      CH_LET_T: c.named_val = CTL_HT;
      CH_LET_V: c.named_val = CTL_VT;
      default:  c.named_val = ch;
    endcase
    return c;
  endfunction

  cesd_item_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wptr_q, rptr_q;
  logic [QCNT_W-1:0]       count_q;
  logic                    push, pop;
  cesd_item_t              new_item;

  // handshake and queue status
  assign in_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    new_item.info = classify(char_in_i);
    new_item.last = last_in_i;
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

[hdl/cesd_back.sv]
`default_nettype none

module cesd_back import cesd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       text_mode_i,
  input  wire logic       q_valid_i,
  input  wire cesd_item_t q_item_i,
  output logic            q_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output cesd_res_t       out_res_o
);

  // decoder state
  logic       esc_q, err_q, step_act_q, last_q;
  logic [1:0] cnt_q, rq_cnt_q;
  cesd_char_t pend_q [3];
  cesd_char_t rq_q   [3];

  // result staging
  cesd_res_t  hold_q, out_q;
  logic       hold_v_q, hold_fin_q, out_v_q;

  logic       out_free, room, go, from_rq, have_ch, last_w, fin;
  cesd_char_t cur;
  cesd_char_t p4   [4];
  cesd_char_t rem4 [4];
  logic [1:0] remc, n_w;

  logic       dec_ok, x0;
  logic [7:0] dec_val;
  logic [1:0] dec_used;

  logic       esc_d, err_d, emit, pend_we, flush, step_end, cont;
  logic [1:0] cnt_d, rq_cnt_d, from_w, k_w;
  cesd_char_t rq_d [3];
  logic [7:0] r_byte;
  logic       r_err;
  cesd_res_t  r_res;
  logic       hold_to_out, fin_now;

  // operation select: rescan queue first, then the closing resolve, then a new character
  assign out_free  = !out_v_q || out_ready_i;
  assign room      = !hold_v_q || out_free;
  assign go        = room && (step_act_q || q_valid_i);
  assign q_ready_o = room && !step_act_q;
  assign from_rq   = step_act_q && (rq_cnt_q != 2'd0);
  assign have_ch   = from_rq || !step_act_q;
  assign fin       = !have_ch;
  assign cur       = from_rq ? rq_q[0] : q_item_i.info;
  assign last_w    = step_act_q ? last_q : q_item_i.last;
  assign n_w       = cnt_q + {1'b0, have_ch};

  // lookahead window with the incoming character in place
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p4[i] = (have_ch && (2'(i) == cnt_q)) ? cur : pend_q[i];
    end
    p4[3] = p4[2];
  end

  // characters still waiting behind the one taken
  always_comb begin
    if (from_rq) begin
      rem4[0] = rq_q[1];
      rem4[1] = rq_q[2];
      rem4[2] = rq_q[2];
      rem4[3] = rq_q[2];
      remc    = rq_cnt_q - 2'd1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        rem4[i] = rq_q[0];
      end
      remc = 2'd0;
    end
  end

  // escape decision over the held characters
  always_comb begin
    dec_ok   = 1'b1;
    dec_val  = p4[0].named_val;
    dec_used = 2'd1;
    x0       = (p4[0].ch == CH_X_LO) || (p4[0].ch == CH_X_UP);
    if (n_w == 2'd0) begin
      // lone trailing backslash
      dec_ok   = fin;
      dec_val  = CH_BSL;
      dec_used = 2'd0;
    end else if (x0) begin
      if ((n_w == 2'd1) || !p4[1].is_hex) begin
        dec_ok   = fin || (n_w != 2'd1);
        dec_val  = p4[0].ch;
        dec_used = 2'd1;
      end else if (n_w == 2'd2) begin
        dec_ok   = fin;
        dec_val  = {4'b0, p4[1].hex_val};
        dec_used = 2'd2;
      end else if (p4[2].is_hex) begin
        dec_val  = {p4[1].hex_val, p4[2].hex_val};
        dec_used = 2'd3;
      end else begin
        dec_val  = {4'b0, p4[1].hex_val};
        dec_used = 2'd2;
      end
    end else if (p4[0].is_oct) begin
      if ((n_w == 2'd1) || !p4[1].is_oct) begin
        dec_ok   = fin || (n_w != 2'd1);
        dec_val  = {5'b0, p4[0].ch[2:0]};
        dec_used = 2'd1;
      end else if (n_w == 2'd2) begin
        dec_ok   = fin;
        dec_val  = {2'b0, p4[0].ch[2:0], p4[1].ch[2:0]};
        dec_used = 2'd2;
      end else if (p4[2].is_oct) begin
        // three digits wrap modulo 256
        dec_val  = {p4[0].ch[1:0], p4[1].ch[2:0], p4[2].ch[2:0]};
        dec_used = 2'd3;
      end else begin
        dec_val  = {2'b0, p4[0].ch[2:0], p4[1].ch[2:0]};
        dec_used = 2'd2;
      end
    end
  end

  // one decode operation
  always_comb begin
    esc_d   = esc_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    emit    = 1'b0;
    pend_we = 1'b0;
    flush   = 1'b0;
    r_byte  = cur.ch;
    r_err   = 1'b0;
    from_w  = 2'd0;
    k_w     = 2'd0;
    if (!err_q) begin
      if (have_ch && !esc_q) begin
        if (cur.is_bsl) begin
          esc_d = 1'b1;
          cnt_d = 2'd0;
        end else if (text_mode_i && cur.is_nul) begin
          // reject the stream
          emit   = 1'b1;
          r_byte = CH_NUL;
          r_err  = 1'b1;
          err_d  = 1'b1;
          esc_d  = 1'b0;
          cnt_d  = 2'd0;
          flush  = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end else begin
        pend_we = have_ch;
        if (!dec_ok) begin
          cnt_d = n_w;
        end else begin
          esc_d = 1'b0;
          cnt_d = 2'd0;
          emit  = 1'b1;
          if (text_mode_i && (dec_val == CH_NUL)) begin
            // zero escape stays literal, held characters are rescanned
            r_byte = CH_BSL;
            from_w = 2'd0;
          end else begin
            r_byte = dec_val;
            from_w = dec_used;
          end
          k_w = n_w - from_w;
        end
      end
    end
  end

  // rescan queue: unused lookahead goes ahead of what still waits
  always_comb begin
    logic [1:0] src;
    logic [1:0] rix;
    for (int i = 0; i < 3; i++) begin
      src = from_w + 2'(i);
      rix = 2'(i) - k_w;
      rq_d[i] = (2'(i) < k_w) ? p4[src] : rem4[rix];
    end
    rq_cnt_d = flush ? 2'd0 : (k_w + remc);
  end

  // end of the work for the current input
  assign cont     = !err_d && ((rq_cnt_d != 2'd0) || (last_w && esc_d));
  assign step_end = !cont;

  always_comb begin
    r_res.byte_val   = r_byte;
    r_res.error      = r_err;
    r_res.run_last   = step_end;
    r_res.stream_end = r_err || (step_end && last_w);
  end

  // staging moves
  assign hold_to_out = hold_v_q && out_free && (hold_fin_q || (go && emit));
  assign fin_now     = go && !emit && step_end && hold_v_q && !hold_fin_q;

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      err_q      <= 1'b0;
      cnt_q      <= 2'd0;
      rq_cnt_q   <= 2'd0;
      step_act_q <= 1'b0;
      last_q     <= 1'b0;
      hold_v_q   <= 1'b0;
      hold_fin_q <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (go) begin
        step_act_q <= cont;
        last_q     <= last_w;
        rq_cnt_q   <= cont ? rq_cnt_d : 2'd0;
        if (step_end && last_w) begin
          esc_q <= 1'b0;
          err_q <= 1'b0;
          cnt_q <= 2'd0;
        end else begin
          esc_q <= esc_d;
          err_q <= err_d;
          cnt_q <= cnt_d;
        end
      end
      if (go && emit) begin
        hold_v_q   <= 1'b1;
        hold_fin_q <= step_end;
      end else if (hold_to_out) begin
        hold_v_q   <= 1'b0;
      end else if (fin_now) begin
        hold_fin_q <= 1'b1;
      end
      if (hold_to_out) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // lookahead, rescan and result payload
  always_ff @(posedge clk_i) begin
    if (go && pend_we) begin
      for (int i = 0; i < 3; i++) begin
        pend_q[i] <= p4[i];
      end
    end
    if (go) begin
      for (int i = 0; i < 3; i++) begin
        rq_q[i] <= rq_d[i];
      end
    end
    if (go && emit) begin
      hold_q <= r_res;
    end else if (fin_now) begin
      hold_q.run_last   <= 1'b1;
      hold_q.stream_end <= hold_q.stream_end || last_w;
    end
    if (hold_to_out) begin
      out_q <= hold_q;
    end
  end

endmodule

`default_nettype wire

[hdl/c_escape_string_decoder.sv]
// a character's first result passes through the queue, the hold stage and the output register
// the back engine does one decode operation per cycle while the hold stage has room; an input takes one operation,
//   plus one per lookahead character rescanned and one for the closing resolve at stream end
// a four-entry front queue and a hold stage let input and output stall independently
// reset: rst_ni asynchronous active low, clears control state and selects byte mode
`default_nettype none

module c_escape_string_decoder import cesd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        last_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       byte_out_o,
  output logic             run_last_o,
  output logic             stream_end_o,
  output logic             error_o
);

  localparam logic REG_TEXT_MODE = 1'b0;

  logic       text_mode_q;
  logic       cfg_wr;
  logic       q_valid, q_ready;
  cesd_item_t q_item;
  cesd_res_t  out_res;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_MODE);
  assign prdata = (paddr[2] == REG_TEXT_MODE) ? {31'b0, text_mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      text_mode_q <= pwdata[0];
    end
  end

  // accept and classify
  cesd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .char_in_i  (char_in_i),
    .last_in_i  (last_in_i),
    .in_ready_o (in_ready_o),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_ready_i  (q_ready)
  );

  // decode engine and result staging
  cesd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_mode_i (text_mode_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_ready_o   (q_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign byte_out_o   = out_res.byte_val;
  assign run_last_o   = out_res.run_last;
  assign stream_end_o = out_res.stream_end;
  assign error_o      = out_res.error;

  // checks
  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> run_last_o)
    else $error("stream end without run last");

  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> stream_end_o && (byte_out_o == 8'h00))
    else $error("error result malformed");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (text_mode_q == $past(pwdata[0])))
    else $error("text mode write lost");

  a_full_queue_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue full but empty toward engine");

endmodule

`default_nettype wire

[dv/tb_c_escape_string_decoder.sv]
`timescale 1ns / 100ps

module tb_c_escape_string_decoder;
  import cesd_pkg::*;

  localparam int          SETTLE_CYCLES = 16;
  localparam int          RANDOM_TARGET = 465;
  localparam logic [2:0]  ADDR_TEXT_MODE = 3'd0;
  localparam logic [2:0]  ADDR_UNUSED    = 3'd4;
  localparam logic [7:0]  CH_SQ = 8'h27;
  localparam logic [7:0]  CH_DQ = 8'h22;
  localparam logic [7:0]  CH_G  = 8'h47;
  localparam logic [7:0]  CH_Z  = 8'h5A;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_in = '0;
  logic        last_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  byte_out;
  logic        run_last;
  logic        stream_end;
  logic        error_flag;

  c_escape_string_decoder dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .char_in_i    (char_in),
    .last_in_i    (last_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .byte_out_o   (byte_out),
    .run_last_o   (run_last),
    .stream_end_o (stream_end),
    .error_o      (error_flag)
  );

  // decoder mirror state
  logic [7:0] esc_hold [3] = '{8'h00, 8'h00, 8'h00};
  int         esc_hold_cnt = 0;
  bit         esc_active = 1'b0;
  bit         stream_dropped = 1'b0;
  bit         text_mode_q = 1'b0;
  logic [7:0] rescan_q [$];
  cesd_res_t  step_bytes [$];
  cesd_res_t  expected_bytes [$];

  int         fails = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  bit         gaps_on = 1'b0;
  logic [31:0] rx_cycle = '0;
  int         rx_style = 0;

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // character classes
  function automatic bit is_hex_digit(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_A_UP && c <= CH_F_UP) ||
           (c >= CH_A_LO && c <= CH_F_LO);
  endfunction

  function automatic bit is_oct_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_7;
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_0 && c <= CH_9) v = c - CH_0;
    else if (c >= CH_A_UP && c <= CH_F_UP) v = c - CH_A_UP + 8'd10;
    else v = c - CH_A_LO + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic [7:0] control_of(input logic [7:0] c);
    case (c)
      CH_LET_A: return CTL_BEL;
      CH_LET_B: return CTL_BS;
      CH_LET_F: return CTL_FF;
      CH_LET_N: return CTL_LF;
      CH_LET_R: return CTL_CR;
      CH_LET_T: return CTL_HT;
      CH_LET_V: return CTL_VT;
      default:  return c;
    endcase
  endfunction

  function automatic void emit_byte(input logic [7:0] b, input logic err);
    cesd_res_t r;
    r.byte_val   = b;
    r.run_last   = 1'b0;
    r.stream_end = err;
    r.error      = err;
    if (step_bytes.size() < 4) step_bytes = {step_bytes, r};
  endfunction

  // value of the held escape; returns 0 while more lookahead is needed
  function automatic bit decode_escape(input int n, input bit at_end,
                                       output logic [7:0] val, output int used);
    logic [7:0] p0, p1, p2;
    logic [5:0] two;
    if (n == 0) begin
      if (!at_end) return 1'b0;
      val = CH_BSL;
      used = 0;
      return 1'b1;
    end
    p0 = esc_hold[0];
    p1 = esc_hold[1];
    p2 = esc_hold[2];
    if (p0 == CH_X_LO || p0 == CH_X_UP) begin
      if (n < 2 || !is_hex_digit(p1)) begin
        if (n < 2 && !at_end) return 1'b0;
        val = p0;
        used = 1;
        return 1'b1;
      end
      if (n < 3) begin
        if (!at_end) return 1'b0;
        val = {4'h0, hex_nibble(p1)};
        used = 2;
        return 1'b1;
      end
      if (is_hex_digit(p2)) begin
        val = {hex_nibble(p1), hex_nibble(p2)};
        used = 3;
      end else begin
        val = {4'h0, hex_nibble(p1)};
        used = 2;
      end
      return 1'b1;
    end
    if (is_oct_digit(p0)) begin
      if (n < 2 || !is_oct_digit(p1)) begin
        if (n < 2 && !at_end) return 1'b0;
        val = {5'd0, p0[2:0]};
        used = 1;
        return 1'b1;
      end
      two = {p0[2:0], p1[2:0]};
      if (n < 3) begin
        if (!at_end) return 1'b0;
        val = {2'd0, two};
        used = 2;
        return 1'b1;
      end
      // three digits wrap modulo 256
      if (is_oct_digit(p2)) begin
        val = {two[4:0], p2[2:0]};
        used = 3;
      end else begin
        val = {2'd0, two};
        used = 2;
      end
      return 1'b1;
    end
    val = control_of(p0);
    used = 1;
    return 1'b1;
  endfunction

  // resolve the open escape and push unused lookahead back for rescanning
  function automatic void close_escape(input bit at_end);
    logic [7:0] v;
    int used, n, from;
    n = esc_hold_cnt;
    if (!decode_escape(n, at_end, v, used)) return;
    esc_active = 1'b0;
    esc_hold_cnt = 0;
    // zero escape in text mode stays literal
    if (text_mode_q && v == CH_NUL) begin
      emit_byte(CH_BSL, 1'b0);
      from = 0;
    end else begin
      emit_byte(v, 1'b0);
      from = used;
    end
    if (n > from && rescan_q.size() + (n - from) <= 8)
      for (int i = n - 1; i >= from; i--) rescan_q.push_front(esc_hold[i]);
  endfunction

  function automatic void scan_chars();
    logic [7:0] ch;
    while (rescan_q.size() > 0 && !stream_dropped) begin
      ch = rescan_q.pop_front();
      if (!esc_active) begin
        if (ch == CH_BSL) begin
          esc_active = 1'b1;
          esc_hold_cnt = 0;
        end else if (text_mode_q && ch == CH_NUL) begin
          emit_byte(CH_NUL, 1'b1);
          stream_dropped = 1'b1;
          esc_active = 1'b0;
          esc_hold_cnt = 0;
          rescan_q.delete();
        end else begin
          emit_byte(ch, 1'b0);
        end
      end else begin
        if (esc_hold_cnt < 3) begin
          esc_hold[esc_hold_cnt] = ch;
          esc_hold_cnt++;
        end
        close_escape(1'b0);
      end
    end
  endfunction

  // expected decoded bytes for one accepted character
  function automatic void predict_char(input logic [7:0] c, input bit fin);
    cesd_res_t r;
    step_bytes.delete();
    rescan_q.delete();
    rescan_q = {rescan_q, c};
    forever begin
      scan_chars();
      if (!fin || stream_dropped || !esc_active) break;
      close_escape(1'b1);
    end
    rescan_q.delete();
    if (step_bytes.size() > 0) begin
      r = step_bytes.pop_back();
      r.run_last = 1'b1;
      if (fin) r.stream_end = 1'b1;
      step_bytes = {step_bytes, r};
    end
    expected_bytes = {expected_bytes, step_bytes};
    if (fin) begin
      stream_dropped = 1'b0;
      esc_active = 1'b0;
      esc_hold_cnt = 0;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    cesd_res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {byte_out, run_last, stream_end, error_flag};
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected transaction byte=%h run_last=%b stream_end=%b error=%b",
                 $time, got.byte_val, got.run_last, got.stream_end, got.error);
        fails++;
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected byte=%h run_last=%b stream_end=%b error=%b",
                   $time, want.byte_val, want.run_last, want.stream_end, want.error);
          $display("%0t:          actual   byte=%h run_last=%b stream_end=%b error=%b",
                   $time, got.byte_val, got.run_last, got.stream_end, got.error);
          fails++;
        end
      end
    end
  end

  // receiver stall pattern, style redrawn at random as rx_cycle counts up
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 200 == 0) rx_style = $urandom_range(0, 3);
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_cycle[1:0] != 2'd0);
      default: out_ready <= (rx_cycle[4:3] != 2'd0);
    endcase
  end

  // one input transaction, with burst gaps when enabled
  task automatic send_char(input logic [7:0] c, input bit fin);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    char_in <= c;
    last_in <= fin;
    do @(posedge clk); while (!in_ready);
    predict_char(c, fin);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic send_stream(input logic [7:0] chars [$]);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // drop valid and wait until the block has drained
  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, setup then access
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_TEXT_MODE) text_mode_q = data[0];
  endtask

  // read of the mode register against the mirror
  task automatic check_mode();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_TEXT_MODE;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'd0, text_mode_q}) begin
      $display("%0t: readback mismatch expected=%h actual=%h",
               $time, {31'd0, text_mode_q}, prdata);
      fails++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write followed by a readback of the mode register
  task automatic set_reg(input logic [2:0] addr, input logic [31:0] data);
    write_reg(addr, data);
    check_mode();
  endtask

  // random stream pieces
  function automatic logic [7:0] rand_hex_digit();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return CH_0 + 8'(r);
    if (r < 16) return CH_A_LO + 8'(r - 10);
    return CH_A_UP + 8'(r - 16);
  endfunction

  function automatic logic [7:0] rand_oct_digit();
    if ($urandom_range(0, 9) < 3) return CH_0;
    return CH_0 + 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] rand_named();
    case ($urandom_range(0, 10))
      0: return CH_LET_A;
      1: return CH_LET_B;
      2: return CH_LET_F;
      3: return CH_LET_N;
      4: return CH_LET_R;
      5: return CH_LET_T;
      6: return CH_LET_V;
      7: return CH_BSL;
      8: return CH_SQ;
      9: return CH_DQ;
      default: return CH_QM;
    endcase
  endfunction

  function automatic void add_token(ref logic [7:0] q [$]);
    int kind, n;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      c = 8'($urandom_range(1, 255));
      q = {q, (c == CH_BSL) ? CH_Z : c};
    end else if (kind < 45) begin
      q = {q, CH_BSL};
      q = {q, rand_named()};
    end else if (kind < 60) begin
      q = {q, CH_BSL};
      q = {q, ($urandom_range(0, 1) != 0) ? CH_X_LO : CH_X_UP};
      n = $urandom_range(0, 2);
      repeat (n) q = {q, rand_hex_digit()};
    end else if (kind < 75) begin
      q = {q, CH_BSL};
      n = $urandom_range(1, 3);
      repeat (n) q = {q, rand_oct_digit()};
    end else if (kind < 85) begin
      q = {q, CH_BSL};
      q = {q, 8'($urandom_range(0, 255))};
    end else if (kind < 89) begin
      q = {q, CH_NUL};
    end else begin
      q = {q, 8'($urandom_range(0, 255))};
    end
  endfunction

  // mode register comes out of reset in byte mode, zero escape decoded as a byte
  task automatic test_reset_state();
    gaps_on = 1'b0;
    check_mode();
    send_stream('{CH_BSL, CH_0, CH_BSL, CH_LET_N});
    go_quiet();
  endtask

  // byte mode: hex, octal wrap, missing hex digit, top byte, trailing backslash
  task automatic test_byte_mode();
    gaps_on = 1'b0;
    set_reg(ADDR_TEXT_MODE, 32'd0);
    send_stream('{CH_BSL, CH_X_LO, CH_0 + 8'd4, CH_0 + 8'd1, CH_BSL, CH_0});
    send_stream('{CH_BSL, CH_7, CH_7, CH_7, CH_BSL, CH_X_UP, CH_G});
    send_stream('{8'hFF, CH_BSL});
    go_quiet();
  endtask

  // text mode: zero escapes stay literal, nul rejects rest of stream
  task automatic test_text_mode();
    gaps_on = 1'b0;
    set_reg(ADDR_TEXT_MODE, 32'd1);
    send_stream('{CH_BSL, CH_0, CH_A_UP, CH_NUL, CH_A_UP + 8'd1, CH_Z});
    send_stream('{CH_BSL, CH_X_LO, CH_0, CH_0});
    go_quiet();
  endtask

  // unused address ignored, only bit 0 of the value kept
  task automatic test_register_decode();
    set_reg(ADDR_TEXT_MODE, 32'hFFFF_FFFF);
    set_reg(ADDR_UNUSED, 32'h0000_0000);
    set_reg(ADDR_TEXT_MODE, 32'hFFFF_FFFE);
    set_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_streams();
    logic [7:0] chars [$];
    int tokens, next_switch, half;
    bit mid_switch;
    next_switch = items_sent + 60;
    while (items_sent < RANDOM_TARGET) begin
      chars.delete();
      if ($urandom_range(0, 9) == 0) begin
        // raw noise stream
        repeat ($urandom_range(1, 8)) chars = {chars, 8'($urandom_range(0, 255))};
      end else begin
        tokens = $urandom_range(1, 6);
        repeat (tokens) add_token(chars);
        if ($urandom_range(0, 9) == 0) chars = {chars, CH_BSL};
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      mid_switch = ($urandom_range(0, 19) == 0) && chars.size() > 1;
      half = chars.size() / 2;
      foreach (chars[i]) begin
        // mode change with the stream still open
        if (mid_switch && i == half) begin
          go_quiet();
          set_reg(ADDR_TEXT_MODE, $urandom_range(0, 1));
        end
        send_char(chars[i], i == chars.size() - 1);
      end
      if (items_sent >= next_switch) begin
        go_quiet();
        set_reg(ADDR_TEXT_MODE, $urandom_range(0, 1));
        next_switch = items_sent + 60;
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_byte_mode();
    test_text_mode();
    test_register_decode();
    test_random_streams();
    go_quiet();
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[c_escape_string_decoder.f]
hdl/cesd_pkg.sv
hdl/cesd_front.sv
hdl/cesd_back.sv
hdl/c_escape_string_decoder.sv
dv/tb_c_escape_string_decoder.sv
